FILE: rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Constants and helpers shared by the binary angle sine/cosine pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int RESULT_FRACTION_BITS = 16;
   localparam int QBITS                = 30;
   localparam int SHIFT                = QBITS - RESULT_FRACTION_BITS;

   localparam int ANGLE_W = 16;
   localparam int FOLD_W  = 15;   // folded angle 0..0x4000
   localparam int OUT_W   = 18;
   localparam int X_W     = 31;   // x   <= pi/2 in Q30
   localparam int X2_W    = 32;   // x^2 <= 2.47 in Q30
   localparam int M_W     = 29;   // x^2 * 1/6, 1/20, 1/42
   localparam int P_W     = 30;   // odd power terms
   localparam int S_W     = 32;
   localparam int MAG_W   = 33;

   localparam int NUM_STAGES = 8;

   localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 16'h4000;
   localparam logic [ANGLE_W-1:0] ANGLE_HALF    = 16'h8000;

   localparam logic [26:0] PI_Q40    = 27'd105414358;
   localparam logic [31:0] INV6_Q30  = 32'd178956971;
   localparam logic [31:0] INV20_Q30 = 32'd53687091;
   localparam logic [31:0] INV42_Q30 = 32'd25565282;

   localparam logic [63:0] Q30_HALF = 64'd1 << (QBITS - 1);
   localparam logic [MAG_W-1:0] ROUND_HALF =
      (SHIFT == 0) ? '0 : (MAG_W'(1) << (SHIFT - 1));
   localparam logic [MAG_W-1:0] ONE_VALUE = MAG_W'(1) << RESULT_FRACTION_BITS;

   // Q30 product, rounded half up
   function automatic logic [31:0] q30_mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b) + Q30_HALF;
      return prod[QBITS+31:QBITS];
   endfunction

endpackage

FILE: rtl/bsc_flow.sv
// ----------------------------------------------------------------------------
// bsc_flow
// Valid tracking and per-stage load enables; bubbles collapse under stall.
// ----------------------------------------------------------------------------
module bsc_flow (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [bsc_pkg::NUM_STAGES-1:0]   stage_load
);
   import bsc_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES:0]   ready;

   always_comb begin
      ready[NUM_STAGES] = !rsp_stall;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_comb begin
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign stage_load = ready[NUM_STAGES-1:0];
   assign req_stall  = !ready[0];
   assign rsp_valid  = valid_ff[NUM_STAGES-1];

endmodule

FILE: rtl/bsc_lane.sv
// ----------------------------------------------------------------------------
// bsc_lane
// One angle: quadrant fold, Taylor series over Q30 multiplies, round, sign.
// ----------------------------------------------------------------------------
module bsc_lane (
   input  logic                                clock,
   input  logic [bsc_pkg::NUM_STAGES-1:0]      stage_load,
   input  logic [bsc_pkg::ANGLE_W-1:0]         angle,
   output logic signed [bsc_pkg::OUT_W-1:0]    result
);
   import bsc_pkg::*;

   logic [ANGLE_W-1:0] half_angle;
   logic [ANGLE_W-1:0] fold_angle;
   logic [FOLD_W-1:0]  quad_angle;
   logic               neg_in;
   logic [41:0]        x_prod;

   logic [NUM_STAGES-2:0] neg_ff;

   logic [X_W-1:0]  x1_ff, x2s_ff, x3_ff, x4_ff, x5_ff, x6_ff;
   logic [X2_W-1:0] sq_ff;
   logic [M_W-1:0]  m6_ff, m20_3_ff, m42_3_ff, m20_4_ff, m42_4_ff, m42_5_ff;
   logic [P_W-1:0]  p3_4_ff, p3_5_ff, p3_6_ff, p5_5_ff, p5_6_ff, p7_ff;
   logic [S_W-1:0]  sum_in, sum_ff;
   logic [MAG_W-1:0] round_sum;
   logic [MAG_W-1:0] mag;
   logic [MAG_W-1:0] signed_mag;
   logic [OUT_W-1:0] result_ff;

   always_comb begin
      neg_in     = angle > ANGLE_HALF;
      half_angle = neg_in ? angle - ANGLE_HALF : angle;
      fold_angle = (half_angle > ANGLE_QUARTER) ? ANGLE_HALF - half_angle : half_angle;
      quad_angle = fold_angle[FOLD_W-1:0];
      x_prod     = 42'(quad_angle) * 42'(PI_Q40) + 42'd512;
   end

   assign sum_in = S_W'(x6_ff) - S_W'(p3_6_ff) + S_W'(p5_6_ff) - S_W'(p7_ff);

   always_comb begin
      round_sum = {1'b0, sum_ff} + ROUND_HALF;
      mag       = MAG_W'(round_sum >> SHIFT);
      if (mag > ONE_VALUE) begin
         mag = ONE_VALUE;
      end
      signed_mag = neg_ff[NUM_STAGES-2] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         neg_ff[0] <= neg_in;
      end
      for (int k = 1; k < NUM_STAGES - 1; k++) begin
         if (stage_load[k]) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end
      if (stage_load[0]) begin
         x1_ff <= x_prod[X_W+9:10];
      end
      if (stage_load[1]) begin
         sq_ff  <= q30_mul(32'(x1_ff), 32'(x1_ff));
         x2s_ff <= x1_ff;
      end
      if (stage_load[2]) begin
         m6_ff    <= M_W'(q30_mul(sq_ff, INV6_Q30));
         m20_3_ff <= M_W'(q30_mul(sq_ff, INV20_Q30));
         m42_3_ff <= M_W'(q30_mul(sq_ff, INV42_Q30));
         x3_ff    <= x2s_ff;
      end
      if (stage_load[3]) begin
         p3_4_ff  <= P_W'(q30_mul(32'(x3_ff), 32'(m6_ff)));
         m20_4_ff <= m20_3_ff;
         m42_4_ff <= m42_3_ff;
         x4_ff    <= x3_ff;
      end
      if (stage_load[4]) begin
         p5_5_ff  <= P_W'(q30_mul(32'(p3_4_ff), 32'(m20_4_ff)));
         p3_5_ff  <= p3_4_ff;
         m42_5_ff <= m42_4_ff;
         x5_ff    <= x4_ff;
      end
      if (stage_load[5]) begin
         p7_ff   <= P_W'(q30_mul(32'(p5_5_ff), 32'(m42_5_ff)));
         p5_6_ff <= p5_5_ff;
         p3_6_ff <= p3_5_ff;
         x6_ff   <= x5_ff;
      end
      if (stage_load[6]) begin
         sum_ff <= sum_in;
      end
      if (stage_load[7]) begin
         result_ff <= signed_mag[OUT_W-1:0];
      end
   end

   assign result = signed'(result_ff);

endmodule

FILE: rtl/binary_angle_sine_cosine_unit.sv
// ----------------------------------------------------------------------------
// binary_angle_sine_cosine_unit
// Sine and cosine of a 16-bit binary angle, signed Q16 results.
// ----------------------------------------------------------------------------
// One angle is taken every cycle while req_stall is low. The pipeline is the
// chain of six dependent Q30 multiplies (x, x^2, the 1/6-1/20-1/42 scalings,
// then x^3, x^5 and x^7 terms), each in a stage of its own, plus a sum stage
// and a round/saturate stage. Sine and cosine run in two parallel lanes.
// Stalled stages hold, empty stages keep filling, so a response waiting on
// rsp_stall does not block input until all eight stages are full.
// ----------------------------------------------------------------------------
module binary_angle_sine_cosine_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bsc_pkg::ANGLE_W-1:0]       req_angle,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bsc_pkg::OUT_W-1:0]  rsp_sine_value,
   output logic signed [bsc_pkg::OUT_W-1:0]  rsp_cosine_value
);
   import bsc_pkg::*;

   logic [NUM_STAGES-1:0] stage_load;
   logic [ANGLE_W-1:0]    cos_angle;

   assign cos_angle = req_angle + ANGLE_QUARTER;

   bsc_flow u_flow (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stage_load (stage_load)
   );

   bsc_lane u_sine (
      .clock      (clock),
      .stage_load (stage_load),
      .angle      (req_angle),
      .result     (rsp_sine_value)
   );

   bsc_lane u_cosine (
      .clock      (clock),
      .stage_load (stage_load),
      .angle      (cos_angle),
      .result     (rsp_cosine_value)
   );

endmodule
